// File: design/nprr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the newton polynomial root refiner
// no dependencies; imported by nprr_if, the top, nprr_dp, nprr_ctrl and nprr_checker

package nprr_pkg;

  localparam int NUM_COEF   = 7;
  localparam int COEF_IDX_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int ITER_W     = 8;

  // register map of the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 3'd7;

  localparam logic [ITER_W-1:0] LIMIT_RESET = 8'd100;

  typedef enum logic [1:0] {
    OUTCOME_CONVERGED  = 2'd0,
    OUTCOME_LIMIT      = 2'd1,
    OUTCOME_ZERO_SLOPE = 2'd2
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ITER,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_STEP,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                  load_guess;
    logic                  iter_begin;
    logic                  mul_start;
    logic                  v_accum;
    logic                  s_accum;
    logic                  div_start;
    logic                  step_apply;
    logic                  est_update;
    logic                  out_load;
    outcome_e              outcome;
    logic [COEF_IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic slope_zero;
    logic converged;
    logic at_limit;
    logic limit_zero;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/nprr_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces of the newton polynomial root refiner
// depends on nprr_pkg

interface nprr_in_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] start_guess;

  modport source (output valid, output start_guess, input ready);
  modport sink   (input valid, input start_guess, output ready);
endinterface

interface nprr_out_if #(
  parameter int WORD_BITS = 32
) ();
  import nprr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] root_estimate;
  logic [1:0]                  outcome;
  logic [ITER_W-1:0]           iterations_used;

  modport source (output valid, output root_estimate, output outcome,
                  output iterations_used, input ready);
  modport sink   (input valid, input root_estimate, input outcome,
                  input iterations_used, output ready);
endinterface

interface nprr_cfg_if #(
  parameter int WORD_BITS = 32
) ();
  import nprr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/newton_poly_root_refine.sv
`timescale 1ns / 1ps
// top level of the newton polynomial root refiner
// depends on nprr_pkg, nprr_if, nprr_ctrl, nprr_dp (nprr_mul, nprr_div)
//
// usage
//   cfg_i : register writes, index 0..6 = coef_0..coef_6, 7 = iteration_limit;
//           always ready, a write is taken on every valid cycle; write only
//           while no guess is in flight
//   in_i  : one starting guess per transfer, signed fixed point
//   out_o : one result per guess: root estimate, outcome, iterations used
// operation (W = WORD_BITS, F = FRACTION_BITS, D = DEGREE)
//   one guess is worked at a time; each newton iteration runs
//   D horner steps on two bit-serial multipliers (value and slope side
//   by side) plus a restoring divider of W+F steps; an iteration that
//   hits a zero slope stops before the division; defaults are Q8.24,
//   degree 6; the result is loaded into the output register from the
//   finish state after its last iteration (iteration_limit 0: after the transfer)
// reset
//   coefficients clear to zero, iteration_limit returns to 100, no result
//   is pending
// stalls
//   the result sits in an output register; the next guess is taken while
//   it waits, and a finished guess holds in the controller until the
//   register frees up

module newton_poly_root_refine
  import nprr_pkg::*;
#(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 24,
  parameter int DEGREE        = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nprr_in_if.sink     in_i,
  nprr_out_if.source  out_o,
  nprr_cfg_if.sink    cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // configuration writes never stall
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  // sequencing of the newton iterations
  nprr_ctrl #(
    .DEGREE (DEGREE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, configuration registers and result register
  nprr_dp #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .DEGREE        (DEGREE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .guess_i     (in_i.start_guess),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .root_o      (out_o.root_estimate),
    .outcome_o   (out_o.outcome),
    .iters_o     (out_o.iterations_used)
  );

endmodule

// File: design/nprr_mul.sv
`timescale 1ns / 1ps
// bit-serial fixed-point multiplier: shift-add over the WORD_BITS multiplier bits,
// then round to nearest (ties away from zero) and saturate; no package use

module nprr_mul #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_o
);

  localparam int W     = WORD_BITS;
  localparam int CNT_W = $clog2(W);
  localparam logic [2*W:0] RND  = (2*W+1)'(1) << (FRACTION_BITS - 1);
  localparam logic [2*W:0] HALF = (2*W+1)'(1) << (W - 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic             busy_q, fin_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     mcand_q, mpl_q;
  logic [2*W-1:0]   prod_q;
  logic             neg_q;
  logic [W-1:0]     res_q;

  logic [W-1:0]   a_mag, b_mag, addend;
  logic [W:0]     sum;
  logic [2*W:0]   rounded, mag;
  logic [W-1:0]   res_d;

  assign a_mag  = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign b_mag  = b_i[W-1] ? (~b_i + W'(1)) : b_i;
  assign addend = mpl_q[0] ? mcand_q : {W{1'b0}};
  assign sum    = {1'b0, prod_q[2*W-1:W]} + {1'b0, addend};

  always_comb begin
    rounded = {1'b0, prod_q} + RND;
    mag     = rounded >> FRACTION_BITS;
    if (mag >= HALF) begin
      res_d = neg_q ? WMIN : WMAX;
    end else begin
      res_d = neg_q ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_mag;
      mpl_q   <= b_mag;
      prod_q  <= '0;
      neg_q   <= a_i[W-1] ^ b_i[W-1];
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[W-1:1]};
      mpl_q  <= mpl_q >> 1;
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: design/nprr_div.sv
`timescale 1ns / 1ps
// restoring divider for the newton step (n << FRACTION_BITS) / d,
// one quotient bit per cycle, truncated toward zero and saturated

module nprr_div #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] num_i,
  input  logic signed [WORD_BITS-1:0] den_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] quo_o
);

  localparam int W     = WORD_BITS;
  localparam int QW    = WORD_BITS + FRACTION_BITS;
  localparam int CNT_W = $clog2(QW);
  localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

  logic             busy_q, fin_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [QW-1:0]    nq_q;
  logic [W-1:0]     rem_q, ud_q;
  logic             neg_q;
  logic [W-1:0]     quo_q;

  logic [W-1:0] n_mag, d_mag;
  logic [W:0]   rem_sh, diff;
  logic         ge;
  logic [W-1:0] quo_d;

  assign n_mag  = num_i[W-1] ? (~num_i + W'(1)) : num_i;
  assign d_mag  = den_i[W-1] ? (~den_i + W'(1)) : den_i;
  assign rem_sh = {rem_q, nq_q[QW-1]};
  assign diff   = rem_sh - {1'b0, ud_q};
  assign ge     = ~diff[W];

  always_comb begin
    if (nq_q >= HALF) begin
      quo_d = neg_q ? WMIN : WMAX;
    end else begin
      quo_d = neg_q ? (~nq_q[W-1:0] + W'(1)) : nq_q[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= {n_mag, {FRACTION_BITS{1'b0}}};
      ud_q  <= d_mag;
      rem_q <= '0;
      neg_q <= num_i[W-1] ^ den_i[W-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      nq_q  <= {nq_q[QW-2:0], ge};
    end
    if (fin_q) begin
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: design/nprr_dp.sv
`timescale 1ns / 1ps
// datapath: coefficient registers, estimate and horner accumulators,
// two serial multipliers, the step divider and the result register; uses nprr_pkg

module nprr_dp
  import nprr_pkg::*;
#(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 24,
  parameter int DEGREE        = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_status_t                  status_o,
  input  logic signed [WORD_BITS-1:0] guess_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [WORD_BITS-1:0]        cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic signed [WORD_BITS-1:0] root_o,
  output logic [1:0]                  outcome_o,
  output logic [ITER_W-1:0]           iters_o
);

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [COEF_IDX_W-1:0] TOP_IDX = COEF_IDX_W'(DEGREE);
  // convergence tolerance, ceil(1e-6 * 2^FRACTION_BITS)
  localparam longint unsigned TOL_Q =
    ((64'd1 << FRACTION_BITS) + 64'd999999) / 64'd1000000;
  localparam logic [W:0] TOL_W =
    ((TOL_Q >> W) != 0) ? {(W+1){1'b1}} : (W+1)'(TOL_Q);

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] sum;
    sum = {a[W-1], a} + {b[W-1], b};
    if (sum[W] != sum[W-1]) begin
      return sum[W] ? WMIN : WMAX;
    end
    return sum[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] dif;
    dif = {a[W-1], a} - {b[W-1], b};
    if (dif[W] != dif[W-1]) begin
      return dif[W] ? WMIN : WMAX;
    end
    return dif[W-1:0];
  endfunction

  // configuration state
  logic [W-1:0]      coef_q  [NUM_COEF];
  logic [W-1:0]      dcoef_q [NUM_COEF];
  logic [ITER_W-1:0] limit_q;

  // iteration state
  logic [W-1:0]      x_q, xn_q, v_q, s_q;
  logic [ITER_W-1:0] cnt_q;

  // result register
  logic              out_valid_q;
  logic [W-1:0]      root_q;
  logic [1:0]        outcome_q;
  logic [ITER_W-1:0] iters_q;

  logic signed [W+3:0] dprod;
  logic [W-1:0]        dsat;
  logic                dfits;
  logic                v_done, s_done, div_done;
  logic signed [W-1:0] v_prod, s_prod, quo;
  logic [W:0]          dx, dx_abs;

  // derivative coefficient i * c_i, saturated, worked out at write time
  assign dprod = $signed({{4{cfg_data_i[W-1]}}, cfg_data_i})
               * $signed({{(W+1){1'b0}}, cfg_idx_i});
  assign dfits = (&dprod[W+3:W-1]) | ~(|dprod[W+3:W-1]);
  assign dsat  = dfits ? dprod[W-1:0] : (dprod[W+3] ? WMIN : WMAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i]  <= '0;
        dcoef_q[i] <= '0;
      end
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_LIMIT) begin
        limit_q <= cfg_data_i[ITER_W-1:0];
      end else begin
        coef_q[cfg_idx_i]  <= cfg_data_i;
        dcoef_q[cfg_idx_i] <= dsat;
      end
    end
  end

  nprr_mul #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (v_q),
    .b_i     (x_q),
    .done_o  (v_done),
    .res_o   (v_prod)
  );

  nprr_mul #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (s_q),
    .b_i     (x_q),
    .done_o  (s_done),
    .res_o   (s_prod)
  );

  nprr_div #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (v_q),
    .den_i   (s_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      xn_q  <= '0;
      v_q   <= '0;
      s_q   <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load_guess) begin
        x_q   <= guess_i;
        cnt_q <= '0;
      end
      if (cmd_i.iter_begin) begin
        cnt_q <= cnt_q + ITER_W'(1);
        v_q   <= coef_q[TOP_IDX];
        s_q   <= dcoef_q[TOP_IDX];
      end
      if (cmd_i.v_accum) begin
        v_q <= sat_add(v_prod, coef_q[cmd_i.idx]);
      end
      if (cmd_i.s_accum) begin
        s_q <= sat_add(s_prod, dcoef_q[cmd_i.idx]);
      end
      if (cmd_i.step_apply) begin
        xn_q <= sat_sub(x_q, quo);
      end
      if (cmd_i.est_update) begin
        x_q <= xn_q;
      end
    end
  end

  // size of the last newton step
  assign dx     = {xn_q[W-1], xn_q} - {x_q[W-1], x_q};
  assign dx_abs = dx[W] ? (~dx + (W+1)'(1)) : dx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      root_q    <= x_q;
      outcome_q <= cmd_i.outcome;
      iters_q   <= cnt_q;
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.mul_done   = v_done & s_done;
    status_o.div_done   = div_done;
    status_o.slope_zero = (s_q == '0);
    status_o.converged  = (dx_abs < TOL_W);
    status_o.at_limit   = (cnt_q == limit_q);
    status_o.limit_zero = (limit_q == '0);
    status_o.out_free   = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;
  assign outcome_o   = outcome_q;
  assign iters_o     = iters_q;

endmodule

// File: design/nprr_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences horner passes, slope check, division and the
// estimate update for one guess at a time; uses nprr_pkg

module nprr_ctrl
  import nprr_pkg::*;
#(
  parameter int DEGREE = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [COEF_IDX_W-1:0] FIRST_IDX = COEF_IDX_W'(DEGREE - 1);

  state_e                state_q, state_d;
  logic [COEF_IDX_W-1:0] idx_q, idx_d;
  outcome_e              outcome_q, outcome_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      outcome_q <= OUTCOME_CONVERGED;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      outcome_q <= outcome_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    outcome_d     = outcome_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.outcome = outcome_q;
    cmd_o.idx     = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_guess = 1'b1;
          if (status_i.limit_zero) begin
            outcome_d = OUTCOME_LIMIT;
            state_d   = ST_FINISH;
          end else begin
            state_d = ST_ITER;
          end
        end
      end
      ST_ITER: begin
        cmd_o.iter_begin = 1'b1;
        idx_d            = FIRST_IDX;
        state_d          = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.v_accum = 1'b1;
          // the slope polynomial is one degree lower
          cmd_o.s_accum = (idx_q != '0);
          if (idx_q == '0) begin
            state_d = ST_CHECK;
          end else begin
            idx_d   = idx_q - COEF_IDX_W'(1);
            state_d = ST_MUL_GO;
          end
        end
      end
      ST_CHECK: begin
        if (status_i.slope_zero) begin
          outcome_d = OUTCOME_ZERO_SLOPE;
          state_d   = ST_FINISH;
        end else begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step_apply = 1'b1;
        state_d          = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.est_update = 1'b1;
        if (status_i.converged) begin
          outcome_d = OUTCOME_CONVERGED;
          state_d   = ST_FINISH;
        end else if (status_i.at_limit) begin
          outcome_d = OUTCOME_LIMIT;
          state_d   = ST_FINISH;
        end else begin
          state_d = ST_ITER;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/nprr_checker.sv
`timescale 1ns / 1ps
// port-level checks of the newton polynomial root refiner, bound to the top
// depends on nprr_pkg and newton_poly_root_refine

module nprr_checker
  import nprr_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [WORD_BITS-1:0] root_i,
  input logic [1:0]           outcome_i,
  input logic [ITER_W-1:0]    iters_i
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(root_i) && $stable(outcome_i) && $stable(iters_i))
    else $error("result changed while stalled");

  // one guess at a time: a transfer in closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on back-to-back cycles");

  // convergence and zero slope both come out of at least one iteration
  a_iter_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i == OUTCOME_CONVERGED || outcome_i == OUTCOME_ZERO_SLOPE)
      |-> iters_i != '0)
    else $error("outcome needs an iteration but count is zero");

endmodule

bind newton_poly_root_refine nprr_checker #(
  .WORD_BITS (WORD_BITS)
) u_nprr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .root_i      (out_o.root_estimate),
  .outcome_i   (out_o.outcome),
  .iters_i     (out_o.iterations_used)
);
